[hw/rtl/spq_pkg.sv]
// spq_pkg: shared types, codes and defaults of the sorted priority queue
// no dependencies; used by spq_cell, spq_ctrl and sorted_priority_queue_top
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 32;

    typedef enum logic [2:0] {
        KIND_INSERT  = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_FIND    = 3'd2,
        KIND_READ    = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [VAL_W-1:0] value;
        logic [3:0]              position;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [3:0]              found_position;
        logic [4:0]              entry_count;
        logic [2:0]              status;
    } t_out;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_POST = 2'd2
    } t_state;

endpackage

[hw/rtl/sorted_priority_queue_top.sv]
// sorted_priority_queue_top: sorted chain of cells with its controller
// depends on spq_pkg, spq_cell, spq_ctrl
`timescale 1ns / 1ps

// channel | valid      | ready       | payload
// --------+------------+-------------+-------------------------
// request | i_in_valid | o_in_ready  | i_in_data  (t_in)
// result  | o_out_valid| i_out_ready | o_out_data (t_out)
//
// insert, dequeue, clear and unused codes finish in the accept cycle; the
//   result sits in the output register on the next cycle
// find and read turn the cell ring one full lap in ST_SCAN, then ST_POST
//   loads the result once the output register is free
// reset is synchronous and clears count and control; cell contents are not reset
// a request is taken only when the output register is free or being drained

module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = $clog2(CAPACITY);

    // ring of cell values and insert-point flags
    logic signed [VAL_W-1:0] w_val   [CAPACITY];
    logic                    w_after [CAPACITY];
    t_cell_ctl               w_ctl;
    logic [CNT_W-1:0]        w_count;

    // controller owns count, sequencing and the result register
    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in_data),
        .i_head      (w_val[0]),
        .o_cell_ctl  (w_ctl),
        .o_count     (w_count),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

    // cell i shifts right on insert, takes cell i+1 on shift; the last cell
    // takes cell 0 so a full lap restores the order
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left_val;
        logic                    w_left_after;

        if (g == 0) begin : g_head
            assign w_left_val   = '0;
            assign w_left_after = 1'b0;
        end else begin : g_body
            assign w_left_val   = w_val[g-1];
            assign w_left_after = w_after[g-1];
        end

        spq_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (w_count),
            .i_left_val   (w_left_val),
            .i_left_after (w_left_after),
            .i_right_val  (w_val[(g + 1) % CAPACITY]),
            .o_val        (w_val[g]),
            .o_after      (w_after[g])
        );
    end

endmodule

[hw/rtl/spq_cell.sv]
// spq_cell: one slot of the sorted chain, compare against the broadcast value
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [CNT_W-1:0]        i_count,
    input  logic signed [VAL_W-1:0] i_left_val,
    input  logic                    i_left_after,
    input  logic signed [VAL_W-1:0] i_right_val,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_after
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    live;

    // slot holds a real entry
    assign live    = 32'(IDX) < 32'(i_count);
    // slot sits at or after the insert point
    assign o_after = !live || (r_val >= i_ctl.value);
    assign o_val   = r_val;

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_left_after) begin
                    n_val = i_left_val;
                end else if (o_after) begin
                    n_val = i_ctl.value;
                end
            end
            CELL_SHIFT: n_val = i_right_val;
            default:    n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[hw/rtl/spq_ctrl.sv]
// spq_ctrl: request sequencing, entry count, ring scan and result register
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int CW       = $clog2(CAPACITY)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in                     i_in,
    input  logic signed [VAL_W-1:0] i_head,
    output t_cell_ctl               o_cell_ctl,
    output logic [CNT_W-1:0]        o_count,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out                    o_out
);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_step;
    t_in                     r_req;
    logic                    r_hit;
    logic [CW-1:0]           r_hit_pos;
    logic signed [VAL_W-1:0] r_res;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid;
    t_out                    r_out;

    logic   out_free;
    logic   accept;
    logic   is_scan;
    logic   full;
    logic   empty;
    logic   last_step;
    logic   load_out;
    t_out   res_now;
    t_out   res_scan;

    assign out_free  = !r_out_valid || i_out_ready;
    assign accept    = i_in_valid && o_in_ready;
    assign is_scan   = (i_in.kind == KIND_FIND) || (i_in.kind == KIND_READ);
    assign full      = 32'(r_count) >= 32'(CAPACITY);
    assign empty     = r_count == '0;
    assign last_step = r_step == CW'(CAPACITY - 1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept && is_scan) n_state = ST_SCAN;
            ST_SCAN: if (last_step) n_state = ST_POST;
            ST_POST: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready       = 1'b0;
        load_out         = 1'b0;
        o_cell_ctl.op    = CELL_HOLD;
        o_cell_ctl.value = i_in.value;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = out_free;
                if (accept && !is_scan) begin
                    load_out = 1'b1;
                end
                if (accept && i_in.kind == KIND_INSERT && !full) begin
                    o_cell_ctl.op = CELL_INSERT;
                end else if (accept && i_in.kind == KIND_DEQUEUE && !empty) begin
                    o_cell_ctl.op = CELL_SHIFT;
                end
            end
            ST_SCAN: o_cell_ctl.op = CELL_SHIFT;
            ST_POST: load_out = out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    // count update and result of the requests that need no ring scan
    always_comb begin
        n_count = r_count;
        res_now = '0;
        if (accept) begin
            case (i_in.kind)
                KIND_INSERT: begin
                    if (full) begin
                        res_now.status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                KIND_DEQUEUE: begin
                    if (empty) begin
                        res_now.status = ST_EMPTY;
                    end else begin
                        res_now.result_value = i_head;
                        n_count = r_count - CNT_W'(1);
                    end
                end
                KIND_CLEAR: n_count = '0;
                default:    n_count = r_count;
            endcase
        end
        res_now.entry_count = 5'(n_count);
    end

    // result of a find or read once the ring has turned
    always_comb begin
        res_scan = '0;
        res_scan.entry_count = 5'(r_count);
        if (r_req.kind == KIND_FIND) begin
            if (!r_hit) begin
                res_scan.status = ST_NOTFOUND;
            end else if (32'(r_hit_pos) > 32'd15) begin
                res_scan.status = ST_RANGE;
            end else begin
                res_scan.found_position = 4'(r_hit_pos);
            end
        end else begin
            if (32'(r_req.position) >= 32'(r_count)) begin
                res_scan.status = ST_RANGE;
            end else begin
                res_scan.result_value = r_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_hit       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_SCAN) begin
                // wrap at the end of the lap for any ring length
                r_step <= last_step ? '0 : r_step + CW'(1);
                if (32'(r_step) < 32'(r_count) && !r_hit && i_head == r_req.value) begin
                    r_hit <= 1'b1;
                end
            end else if (accept) begin
                r_step <= '0;
                r_hit  <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in;
        end
        if (r_state == ST_SCAN) begin
            if (32'(r_step) < 32'(r_count) && !r_hit && i_head == r_req.value) begin
                r_hit_pos <= r_step;
            end
            if (32'(r_step) == 32'(r_req.position)) begin
                r_res <= i_head;
            end
        end
        if (load_out) begin
            r_out <= (r_state == ST_POST) ? res_scan : res_now;
        end
    end

    assign o_count     = r_count;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(CAPACITY))
        else $error("entry count beyond capacity");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("request taken during a scan");

    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POST) |-> (r_step == '0))
        else $error("scan did not complete a full turn");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.kind == KIND_INSERT && !full)
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");
`endif

endmodule
